// ===== rtl/mhc_pkg.sv =====
package mhc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WATER = 3'd1,
        MODE_VENT  = 3'd2,
        MODE_COOL  = 3'd3,
        MODE_ERROR = 3'd4
    } t_mode;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_ERROR  = 2'd2;

    localparam logic [2:0] REG_DRY_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_WET_THRESHOLD     = 3'd1;
    localparam logic [2:0] REG_HYSTERESIS_MARGIN = 3'd2;
    localparam logic [2:0] REG_PUMP_TIME_MS      = 3'd3;
    localparam logic [2:0] REG_FAN_TIME_MS       = 3'd4;
    localparam logic [2:0] REG_COOLDOWN_TIME_MS  = 3'd5;

    localparam logic [9:0]  DRY_THRESHOLD_RST     = 10'd700;
    localparam logic [9:0]  WET_THRESHOLD_RST     = 10'd300;
    localparam logic [9:0]  HYSTERESIS_MARGIN_RST = 10'd50;
    localparam logic [31:0] PUMP_TIME_MS_RST      = 32'd10000;
    localparam logic [31:0] FAN_TIME_MS_RST       = 32'd30000;
    localparam logic [31:0] COOLDOWN_TIME_MS_RST  = 32'd60000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] moisture;
        logic       sensor_healthy;
    } t_in_item;

    typedef struct packed {
        logic [2:0] state_code;
        logic [2:0] prior_state;
        logic       pump_on;
        logic       fan_on;
        logic       state_changed;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [31:0] wr_data;
    } t_cfg_item;

endpackage

// ===== rtl/mhc_chan_if.sv =====
interface mhc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/moisture_hysteresis_cycle_controller.sv =====
// Greenhouse moisture controller: idle, watering, venting, cooldown, error.
// Channels (valid/ready, a transfer happens when both are high):
//   i_in  : items of type t_in_item (moisture sample, millisecond tick,
//           error event), one result per item.
//   o_out : results of type t_out_item (state, prior state, relay drives,
//           transition flag).
//   i_cfg : register writes of type t_cfg_item; always ready, write only
//           while no item is in flight.
// Results are registered: in the result register, or in the skid register.
// Throughput: one item per cycle while i_in.ready is high; the state update is
// combinational compares and a 32-bit saturating increment between the mode
// register and the result register.
// Stall: a two-entry output (result register plus skid register) keeps
// i_in.ready high for one more item after o_out.ready drops; i_in.ready
// falls only once both entries hold results.
// Reset: synchronous, active low; state returns to idle, elapsed count to
// zero, registers to their default values, output empty.
module moisture_hysteresis_cycle_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mhc_chan_if.sink       i_in,
    mhc_chan_if.source     o_out,
    mhc_chan_if.sink       i_cfg
);

    logic [9:0]  r_dry_threshold;
    logic [9:0]  r_wet_threshold;
    logic [9:0]  r_hysteresis_margin;
    logic [31:0] r_pump_time_ms;
    logic [31:0] r_fan_time_ms;
    logic [31:0] r_cooldown_time_ms;

    mhc_pkg::t_mode r_mode;
    mhc_pkg::t_mode n_mode;
    mhc_pkg::t_mode r_prev;
    mhc_pkg::t_mode n_prev;
    logic [31:0]    r_elapsed;
    logic [31:0]    n_elapsed;

    mhc_pkg::t_out_item r_out;
    mhc_pkg::t_out_item r_skid;
    mhc_pkg::t_out_item result;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_skid_valid;
    logic               n_skid_valid;
    logic               load_out;
    logic               load_skid;
    logic               out_from_skid;

    mhc_pkg::t_in_item in_item;
    logic              in_accept;
    logic              out_taken;
    logic              cfg_accept;
    logic              changed;

    logic [31:0]        elapsed_inc;
    logic signed [10:0] dry_stop;
    logic signed [10:0] moist_s;
    logic [10:0]        wet_stop;

    assign in_item     = i_in.data;
    assign i_in.ready  = !r_skid_valid;
    assign in_accept   = i_in.valid && i_in.ready;
    assign out_taken   = r_out_valid && o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry_threshold     <= mhc_pkg::DRY_THRESHOLD_RST;
            r_wet_threshold     <= mhc_pkg::WET_THRESHOLD_RST;
            r_hysteresis_margin <= mhc_pkg::HYSTERESIS_MARGIN_RST;
            r_pump_time_ms      <= mhc_pkg::PUMP_TIME_MS_RST;
            r_fan_time_ms       <= mhc_pkg::FAN_TIME_MS_RST;
            r_cooldown_time_ms  <= mhc_pkg::COOLDOWN_TIME_MS_RST;
        end else if (cfg_accept) begin
            unique case (i_cfg.data.reg_index)
                mhc_pkg::REG_DRY_THRESHOLD: begin
                    r_dry_threshold <= i_cfg.data.wr_data[9:0];
                end
                mhc_pkg::REG_WET_THRESHOLD: begin
                    r_wet_threshold <= i_cfg.data.wr_data[9:0];
                end
                mhc_pkg::REG_HYSTERESIS_MARGIN: begin
                    r_hysteresis_margin <= i_cfg.data.wr_data[9:0];
                end
                mhc_pkg::REG_PUMP_TIME_MS: begin
                    r_pump_time_ms <= i_cfg.data.wr_data;
                end
                mhc_pkg::REG_FAN_TIME_MS: begin
                    r_fan_time_ms <= i_cfg.data.wr_data;
                end
                mhc_pkg::REG_COOLDOWN_TIME_MS: begin
                    r_cooldown_time_ms <= i_cfg.data.wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 32'd1;
    assign dry_stop    = $signed({1'b0, r_dry_threshold}) - $signed({1'b0, r_hysteresis_margin});
    assign moist_s     = $signed({1'b0, in_item.moisture});
    assign wet_stop    = {1'b0, r_wet_threshold} + {1'b0, r_hysteresis_margin};

    // next state
    always_comb begin
        n_mode = r_mode;
        case (in_item.cmd)
            mhc_pkg::CMD_SAMPLE: begin
                unique case (r_mode)
                    mhc_pkg::MODE_IDLE: begin
                        if (in_item.moisture >= r_dry_threshold) begin
                            n_mode = mhc_pkg::MODE_WATER;
                        end else if (in_item.moisture <= r_wet_threshold) begin
                            n_mode = mhc_pkg::MODE_VENT;
                        end
                    end
                    mhc_pkg::MODE_WATER: begin
                        if (moist_s < dry_stop) begin
                            n_mode = mhc_pkg::MODE_COOL;
                        end
                    end
                    mhc_pkg::MODE_VENT: begin
                        if ({1'b0, in_item.moisture} > wet_stop) begin
                            n_mode = mhc_pkg::MODE_COOL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mhc_pkg::CMD_TICK: begin
                unique case (r_mode)
                    mhc_pkg::MODE_WATER: begin
                        if (elapsed_inc >= r_pump_time_ms) begin
                            n_mode = mhc_pkg::MODE_COOL;
                        end
                    end
                    mhc_pkg::MODE_VENT: begin
                        if (elapsed_inc >= r_fan_time_ms) begin
                            n_mode = mhc_pkg::MODE_COOL;
                        end
                    end
                    mhc_pkg::MODE_COOL: begin
                        if (elapsed_inc >= r_cooldown_time_ms) begin
                            n_mode = mhc_pkg::MODE_IDLE;
                        end
                    end
                    mhc_pkg::MODE_ERROR: begin
                        if (in_item.sensor_healthy) begin
                            n_mode = mhc_pkg::MODE_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mhc_pkg::CMD_ERROR: begin
                n_mode = mhc_pkg::MODE_ERROR;
            end
            default: begin
            end
        endcase
    end

    // outputs of the state update
    always_comb begin
        changed   = (n_mode != r_mode);
        n_prev    = changed ? r_mode : r_prev;
        n_elapsed = r_elapsed;
        if (changed) begin
            n_elapsed = '0;
        end else if (in_item.cmd == mhc_pkg::CMD_TICK) begin
            n_elapsed = elapsed_inc;
        end
        result.state_code    = n_mode;
        result.prior_state   = n_prev;
        result.pump_on       = (n_mode == mhc_pkg::MODE_WATER);
        result.fan_on        = (n_mode == mhc_pkg::MODE_VENT);
        result.state_changed = changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= mhc_pkg::MODE_IDLE;
            r_prev    <= mhc_pkg::MODE_IDLE;
            r_elapsed <= '0;
        end else if (in_accept) begin
            r_mode    <= n_mode;
            r_prev    <= n_prev;
            r_elapsed <= n_elapsed;
        end
    end

    // output register and skid steering
    always_comb begin
        n_out_valid   = r_out_valid && !out_taken;
        n_skid_valid  = r_skid_valid;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        out_from_skid = 1'b0;
        if (r_skid_valid) begin
            if (out_taken) begin
                out_from_skid = 1'b1;
                n_out_valid   = 1'b1;
                n_skid_valid  = 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_taken) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_from_skid) begin
            r_out <= r_skid;
        end else if (load_out) begin
            r_out <= result;
        end
        if (load_skid) begin
            r_skid <= result;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_change_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.state_changed) |-> (r_out.state_code != r_out.prior_state))
        else $error("transition reported with equal state and prior state");

    a_error_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_item.cmd == mhc_pkg::CMD_ERROR) |=> (r_mode == mhc_pkg::MODE_ERROR))
        else $error("error event did not enter error state");

    a_mode_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> ($stable(r_mode) && $stable(r_elapsed)))
        else $error("state moved without an input transfer");

    a_transition_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && changed) |=> (r_elapsed == '0))
        else $error("elapsed count not cleared on transition");

endmodule

// ===== sim/mhc_mode_checker.sv =====
module mhc_mode_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mhc_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mhc_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  mhc_pkg::t_cfg_item i_cfg_data,
    output int                 o_failures,
    output int                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [9:0]  dry_thr;
    logic [9:0]  wet_thr;
    logic [9:0]  margin;
    logic [31:0] pump_ms;
    logic [31:0] fan_ms;
    logic [31:0] cool_ms;

    mhc_pkg::t_mode mode_now;
    mhc_pkg::t_mode mode_before;
    logic [31:0]    elapsed;

    mhc_pkg::t_out_item expected_results[$];
    int                 failures = 0;
    int                 outstanding = 0;

    assign o_failures    = failures;
    assign o_outstanding = outstanding;

    function automatic logic switch_mode(mhc_pkg::t_mode next);
        if (next == mode_now) begin
            return 1'b0;
        end
        mode_before = mode_now;
        mode_now    = next;
        elapsed     = '0;
        return 1'b1;
    endfunction

    function automatic mhc_pkg::t_out_item advance_mode(mhc_pkg::t_in_item it);
        int                 dry_stop;
        int                 wet_stop;
        logic               moved;
        mhc_pkg::t_out_item res;
        dry_stop = int'(dry_thr) - int'(margin);
        wet_stop = int'(wet_thr) + int'(margin);
        moved    = 1'b0;
        case (it.cmd)
            mhc_pkg::CMD_SAMPLE: begin
                case (mode_now)
                    mhc_pkg::MODE_IDLE: begin
                        if (it.moisture >= dry_thr) begin
                            moved = switch_mode(mhc_pkg::MODE_WATER);
                        end else if (it.moisture <= wet_thr) begin
                            moved = switch_mode(mhc_pkg::MODE_VENT);
                        end
                    end
                    mhc_pkg::MODE_WATER: begin
                        if (int'(it.moisture) < dry_stop) begin
                            moved = switch_mode(mhc_pkg::MODE_COOL);
                        end
                    end
                    mhc_pkg::MODE_VENT: begin
                        if (int'(it.moisture) > wet_stop) begin
                            moved = switch_mode(mhc_pkg::MODE_COOL);
                        end
                    end
                    default: ;
                endcase
            end
            mhc_pkg::CMD_TICK: begin
                // saturate, then compare against the new count
                if (elapsed != '1) begin
                    elapsed = elapsed + 32'd1;
                end
                case (mode_now)
                    mhc_pkg::MODE_WATER: begin
                        if (elapsed >= pump_ms) begin
                            moved = switch_mode(mhc_pkg::MODE_COOL);
                        end
                    end
                    mhc_pkg::MODE_VENT: begin
                        if (elapsed >= fan_ms) begin
                            moved = switch_mode(mhc_pkg::MODE_COOL);
                        end
                    end
                    mhc_pkg::MODE_COOL: begin
                        if (elapsed >= cool_ms) begin
                            moved = switch_mode(mhc_pkg::MODE_IDLE);
                        end
                    end
                    mhc_pkg::MODE_ERROR: begin
                        if (it.sensor_healthy) begin
                            moved = switch_mode(mhc_pkg::MODE_IDLE);
                        end
                    end
                    default: ;
                endcase
            end
            mhc_pkg::CMD_ERROR: begin
                moved = switch_mode(mhc_pkg::MODE_ERROR);
            end
            default: ;
        endcase
        res.state_code    = mode_now;
        res.prior_state   = mode_before;
        res.pump_on       = (mode_now == mhc_pkg::MODE_WATER);
        res.fan_on        = (mode_now == mhc_pkg::MODE_VENT);
        res.state_changed = moved;
        return res;
    endfunction

    task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        mhc_pkg::t_out_item want;
        if (!i_rst_n) begin
            dry_thr     = mhc_pkg::DRY_THRESHOLD_RST;
            wet_thr     = mhc_pkg::WET_THRESHOLD_RST;
            margin      = mhc_pkg::HYSTERESIS_MARGIN_RST;
            pump_ms     = mhc_pkg::PUMP_TIME_MS_RST;
            fan_ms      = mhc_pkg::FAN_TIME_MS_RST;
            cool_ms     = mhc_pkg::COOLDOWN_TIME_MS_RST;
            mode_now    = mhc_pkg::MODE_IDLE;
            mode_before = mhc_pkg::MODE_IDLE;
            elapsed     = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.reg_index)
                    mhc_pkg::REG_DRY_THRESHOLD:     dry_thr = i_cfg_data.wr_data[9:0];
                    mhc_pkg::REG_WET_THRESHOLD:     wet_thr = i_cfg_data.wr_data[9:0];
                    mhc_pkg::REG_HYSTERESIS_MARGIN: margin  = i_cfg_data.wr_data[9:0];
                    mhc_pkg::REG_PUMP_TIME_MS:      pump_ms = i_cfg_data.wr_data;
                    mhc_pkg::REG_FAN_TIME_MS:       fan_ms  = i_cfg_data.wr_data;
                    mhc_pkg::REG_COOLDOWN_TIME_MS:  cool_ms = i_cfg_data.wr_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(advance_mode(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    failures++;
                    $display("%0t: result expected none actual %p", $time, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("state_code", want.state_code, i_out_data.state_code);
                    check_field("prior_state", want.prior_state, i_out_data.prior_state);
                    check_field("pump_on", 3'(want.pump_on), 3'(i_out_data.pump_on));
                    check_field("fan_on", 3'(want.fan_on), 3'(i_out_data.fan_on));
                    check_field("state_changed", 3'(want.state_changed),
                                3'(i_out_data.state_changed));
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES    = 60;

    typedef struct {
        logic [9:0]  dry;
        logic [9:0]  wet;
        logic [9:0]  margin;
        logic [31:0] pump;
        logic [31:0] fan;
        logic [31:0] cool;
    } t_regs;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    bit    quiet = 1'b0;
    bit    hold_request = 1'b0;
    int    failures;
    int    outstanding;
    int    idle_cycles = 0;
    t_regs regs;

    mhc_chan_if #(.T(mhc_pkg::t_in_item))  in_ch ();
    mhc_chan_if #(.T(mhc_pkg::t_out_item)) out_ch ();
    mhc_chan_if #(.T(mhc_pkg::t_cfg_item)) cfg_ch ();

    always #10 clk = ~clk;

    moisture_hysteresis_cycle_controller dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mhc_mode_checker mode_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_data     (in_ch.data),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_data    (out_ch.data),
        .i_cfg_valid   (cfg_ch.valid),
        .i_cfg_ready   (cfg_ch.ready),
        .i_cfg_data    (cfg_ch.data),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [9:0] pick_moisture();
        int v;
        case ($urandom_range(0, 5))
            0: v = int'(regs.dry) + int'($urandom_range(0, 4)) - 2;
            1: v = int'(regs.dry) - int'(regs.margin) + int'($urandom_range(0, 2)) - 1;
            2: v = int'(regs.wet) + int'($urandom_range(0, 4)) - 2;
            3: v = int'(regs.wet) + int'(regs.margin) + int'($urandom_range(0, 2)) - 1;
            4: v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
            default: v = $urandom_range(0, 1023);
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > 1023) begin
            v = 1023;
        end
        return v[9:0];
    endfunction

    function automatic logic [31:0] pick_run_time();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom();
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic t_regs random_regs();
        t_regs r;
        r.dry    = 10'($urandom_range(0, 1023));
        r.wet    = 10'($urandom_range(0, 1023));
        r.margin = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                               : 10'($urandom_range(0, 60));
        r.pump   = pick_run_time();
        r.fan    = pick_run_time();
        r.cool   = pick_run_time();
        return r;
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [9:0] moisture, logic healthy);
        mhc_pkg::t_in_item it;
        int                gap;
        it.cmd            = cmd;
        it.moisture       = moisture;
        it.sensor_healthy = healthy;
        gap               = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic random_items(int count);
        int         pick;
        logic [1:0] cmd;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                cmd = mhc_pkg::CMD_SAMPLE;
            end else if (pick < 85) begin
                cmd = mhc_pkg::CMD_TICK;
            end else if (pick < 94) begin
                cmd = mhc_pkg::CMD_ERROR;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_item(cmd, pick_moisture(), $urandom_range(0, 9) < 7);
        end
    endtask

    // drop valid and wait until every transfer has its result
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_settings(t_regs r);
        mhc_pkg::t_cfg_item wr[6];
        regs  = r;
        wr[0] = '{reg_index: mhc_pkg::REG_DRY_THRESHOLD,     wr_data: {22'd0, r.dry}};
        wr[1] = '{reg_index: mhc_pkg::REG_WET_THRESHOLD,     wr_data: {22'd0, r.wet}};
        wr[2] = '{reg_index: mhc_pkg::REG_HYSTERESIS_MARGIN, wr_data: {22'd0, r.margin}};
        wr[3] = '{reg_index: mhc_pkg::REG_PUMP_TIME_MS,      wr_data: r.pump};
        wr[4] = '{reg_index: mhc_pkg::REG_FAN_TIME_MS,       wr_data: r.fan};
        wr[5] = '{reg_index: mhc_pkg::REG_COOLDOWN_TIME_MS,  wr_data: r.cool};
        foreach (wr[k]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= wr[k];
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int gap;
        int burst;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ch.ready <= 1'b1;
                burst = $urandom_range(1, 8);
                repeat (burst) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        regs = '{dry: mhc_pkg::DRY_THRESHOLD_RST, wet: mhc_pkg::WET_THRESHOLD_RST,
                 margin: mhc_pkg::HYSTERESIS_MARGIN_RST, pump: mhc_pkg::PUMP_TIME_MS_RST,
                 fan: mhc_pkg::FAN_TIME_MS_RST, cool: mhc_pkg::COOLDOWN_TIME_MS_RST};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(mhc_pkg::CMD_SAMPLE, 10'd500,  1'b0);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd700,  1'b0);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd650,  1'b1);
        send_item(mhc_pkg::CMD_TICK,   10'd0,    1'b1);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd649,  1'b0);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd1023, 1'b1);
        send_item(mhc_pkg::CMD_TICK,   10'd1023, 1'b0);
        send_item(mhc_pkg::CMD_ERROR,  10'd0,    1'b1);
        send_item(mhc_pkg::CMD_ERROR,  10'd1023, 1'b0);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd0,    1'b1);
        send_item(mhc_pkg::CMD_TICK,   10'd0,    1'b0);
        send_item(mhc_pkg::CMD_TICK,   10'd0,    1'b1);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd300,  1'b0);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd350,  1'b1);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd351,  1'b0);
        send_item(mhc_pkg::CMD_ERROR,  10'd0,    1'b0);
        send_item(mhc_pkg::CMD_TICK,   10'd0,    1'b1);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd1023, 1'b1);
        send_item(mhc_pkg::CMD_ERROR,  10'd0,    1'b1);
        send_item(mhc_pkg::CMD_TICK,   10'd0,    1'b1);
        send_item(mhc_pkg::CMD_SAMPLE, 10'd0,    1'b0);
        send_item(mhc_pkg::CMD_ERROR,  10'd0,    1'b0);
        send_item(CMD_UNUSED,          10'd1023, 1'b1);
        send_item(mhc_pkg::CMD_TICK,   10'd0,    1'b1);
        send_item(mhc_pkg::CMD_ERROR,  10'd0,    1'b0);
        settle();

        load_settings('{dry: 10'd1023, wet: 10'd0, margin: 10'd1023,
                        pump: 32'd0, fan: 32'd0, cool: 32'd0});
        random_items(40);
        settle();

        load_settings('{dry: 10'd0, wet: 10'd1023, margin: 10'd0,
                        pump: 32'd1, fan: 32'd2, cool: 32'd3});
        random_items(40);
        settle();

        // back-to-back transfers, then a long receiver hold to fill the block
        load_settings('{dry: 10'd600, wet: 10'd400, margin: 10'd30,
                        pump: 32'd5, fan: 32'd7, cool: 32'd4});
        quiet = 1'b1;
        random_items(20);
        hold_request = 1'b1;
        random_items(40);
        quiet = 1'b0;
        settle();

        load_settings('{dry: 10'd512, wet: 10'd511, margin: 10'd1,
                        pump: 32'hFFFF_FFFF, fan: 32'hFFFF_FFFF, cool: 32'hFFFF_FFFF});
        random_items(40);
        settle();

        for (int p = 0; p < 5; p++) begin
            load_settings(random_regs());
            random_items(45);
            settle();
        end

        repeat (4) @(posedge clk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
